FILE: hdl/reif_pkg.sv
// Shared types and constants for the run-end index finder.
// Used by the sequencer, the step unit, the top level and the port checker.
// No dependencies.
package reif_pkg;

  // Fixed field widths of the item and register formats.
  localparam int OFF_W   = 31;  // logical offset and logical index
  localparam int NRUN_W  = 11;  // num_runs register
  localparam int SLOT_W  = 10;  // entry_index of a load item
  localparam int VAL_W   = 31;  // run_end_value of a load item
  localparam int PHYS_W  = 10;  // physical_index of a result item
  localparam int ADDR_W  = 3;   // APB address width

  // Item kinds carried in the input tuser.
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Register selects, taken from paddr bit 2.
  localparam logic REG_OFFSET   = 1'b0;
  localparam logic REG_NUM_RUNS = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAST,
    S_CACHE,
    S_PREV,
    S_SEARCH,
    S_EMIT
  } state_e;

  // One accepted input item, handed from the top level to the sequencer.
  typedef struct packed {
    logic                valid;
    logic                action;
    logic [SLOT_W-1:0]   entry_index;
    logic [VAL_W-1:0]    run_end_value;
    logic [OFF_W-1:0]    logical_index;
  } cmd_t;

  // A finished result offered by the sequencer.
  typedef struct packed {
    logic              valid;
    logic [PHYS_W-1:0] phys;
    logic              oor;
  } res_t;

endpackage

FILE: hdl/reif_step.sv
// Shared compare and bisection step unit of the run-end index finder.
// Depends on reif_pkg for the position width.
module reif_step import reif_pkg::*; #(
  parameter int RW = 31,
  parameter int NW = 11
) (
  input  logic [OFF_W:0]  pos_i,
  input  logic [RW-1:0]   rdata_i,
  input  logic            adv_i,
  input  logic [NW-1:0]   lo_i,
  input  logic [NW-1:0]   cnt_i,
  output logic            ge_o,
  output logic [NW-1:0]   lo_o,
  output logic [NW-1:0]   cnt_o,
  output logic [NW-1:0]   probe_o
);

  localparam int PW   = OFF_W + 1;
  localparam int CMPW = (RW > PW) ? RW : PW;

  logic [NW-1:0] step;

  assign ge_o = CMPW'(pos_i) >= CMPW'(rdata_i);
  assign step = cnt_i >> 1;

  always_comb begin
    lo_o  = lo_i;
    cnt_o = cnt_i;
    if (adv_i) begin
      if (ge_o) begin
        // The probed run ends at or before the position: move past it.
        lo_o  = lo_i + step + 1'b1;
        cnt_o = cnt_i - step - 1'b1;
      end else begin
        cnt_o = step;
      end
    end
    probe_o = lo_o + (cnt_o >> 1);
  end

endmodule

FILE: hdl/reif_seq.sv
// Sequencer of the run-end index finder: holds the run-end table memory,
// the cached run and the search registers, and drives the shared step unit.
// Depends on reif_pkg and reif_step.
module reif_seq import reif_pkg::*; #(
  parameter int MAX_RUNS     = 1024,
  parameter int RUN_END_BITS = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output logic              cmd_ready_o,
  input  logic [OFF_W-1:0]  offset_i,
  input  logic [NRUN_W-1:0] num_runs_i,
  input  logic              cfg_wr_i,
  output res_t              res_o,
  input  logic              res_ready_i
);

  localparam int IW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int NW = $clog2(MAX_RUNS + 1);
  localparam int PW = OFF_W + 1;

  state_e state_q, state_d;

  logic [RUN_END_BITS-1:0] mem [MAX_RUNS];
  logic [RUN_END_BITS-1:0] rdata_q;
  logic                    rd_en;
  logic [IW-1:0]           rd_addr;

  logic [PW-1:0]     pos_q, pos_d;
  logic [NW-1:0]     n_q, n_d, n_new;
  logic [NW-1:0]     c_q, c_d;
  logic [NW-1:0]     lo_q, lo_d, cnt_q, cnt_d;
  logic [PHYS_W-1:0] cache_q, cache_d;
  logic [PHYS_W-1:0] phys_q, phys_d;
  logic              oor_q, oor_d;

  logic          ge, adv;
  logic [NW-1:0] lo_in, cnt_in, lo_o, cnt_o, probe_o;
  logic          done;
  logic [NW-1:0] r_val, r_sat;
  logic          is_query, is_load;

  assign is_query = cmd_i.valid && (cmd_i.action == ACT_QUERY);
  assign is_load  = cmd_i.valid && (cmd_i.action == ACT_LOAD);
  assign n_new    = (32'(num_runs_i) > MAX_RUNS) ? NW'(MAX_RUNS) : NW'(num_runs_i);
  assign r_sat    = (r_val >= n_q) ? (n_q - 1'b1) : r_val;

  reif_step #(
    .RW (RUN_END_BITS),
    .NW (NW)
  ) u_step (
    .pos_i   (pos_q),
    .rdata_i (rdata_q),
    .adv_i   (adv),
    .lo_i    (lo_in),
    .cnt_i   (cnt_in),
    .ge_o    (ge),
    .lo_o    (lo_o),
    .cnt_o   (cnt_o),
    .probe_o (probe_o)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (is_query) begin
          state_d = (n_new == '0) ? S_EMIT : S_LAST;
        end
      end
      S_LAST: begin
        state_d = ge ? S_EMIT : S_CACHE;
      end
      S_CACHE: begin
        if (!ge) begin
          state_d = (c_q == '0) ? S_EMIT : S_PREV;
        end else begin
          state_d = (cnt_o == '0) ? S_EMIT : S_SEARCH;
        end
      end
      S_PREV: begin
        state_d = ge ? S_EMIT : S_SEARCH;
      end
      S_SEARCH: begin
        state_d = (cnt_o == '0) ? S_EMIT : S_SEARCH;
      end
      S_EMIT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath control and outputs.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = IW'(probe_o);
    adv     = 1'b0;
    lo_in   = lo_q;
    cnt_in  = cnt_q;
    lo_d    = lo_q;
    cnt_d   = cnt_q;
    c_d     = c_q;
    pos_d   = pos_q;
    n_d     = n_q;
    done    = 1'b0;
    r_val   = c_q;
    phys_d  = phys_q;
    oor_d   = oor_q;
    unique case (state_q)
      S_IDLE: begin
        pos_d = PW'(offset_i) + PW'(cmd_i.logical_index);
        n_d   = n_new;
        if (is_query) begin
          if (n_new == '0) begin
            phys_d = '0;
            oor_d  = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = IW'(n_new - 1'b1);
          end
        end
      end
      S_LAST: begin
        if (ge) begin
          phys_d = '0;
          oor_d  = 1'b1;
        end else begin
          // A cached run at or beyond the current run count falls back to run 0.
          c_d     = (32'(cache_q) >= 32'(n_q)) ? '0 : NW'(cache_q);
          rd_en   = 1'b1;
          rd_addr = IW'(c_d);
        end
      end
      S_CACHE: begin
        if (!ge) begin
          if (c_q == '0) begin
            done = 1'b1;
          end else begin
            rd_en   = 1'b1;
            rd_addr = IW'(c_q - 1'b1);
          end
        end else begin
          lo_in  = c_q + 1'b1;
          cnt_in = n_q - c_q - 1'b1;
          lo_d   = lo_o;
          cnt_d  = cnt_o;
          if (cnt_o == '0) begin
            done  = 1'b1;
            r_val = lo_o;
          end else begin
            rd_en = 1'b1;
          end
        end
      end
      S_PREV: begin
        if (ge) begin
          done = 1'b1;
        end else begin
          lo_in  = '0;
          cnt_in = c_q;
          lo_d   = lo_o;
          cnt_d  = cnt_o;
          rd_en  = 1'b1;
        end
      end
      S_SEARCH: begin
        adv   = 1'b1;
        lo_d  = lo_o;
        cnt_d = cnt_o;
        if (cnt_o == '0) begin
          done  = 1'b1;
          r_val = lo_o;
        end else begin
          rd_en = 1'b1;
        end
      end
      S_EMIT: begin
      end
      default: begin
      end
    endcase
    if (done) begin
      phys_d = PHYS_W'(r_sat);
      oor_d  = 1'b0;
    end
  end

  always_comb begin
    cache_d = cache_q;
    if (is_load || cfg_wr_i) begin
      cache_d = '0;
    end else if (done) begin
      cache_d = PHYS_W'(r_sat);
    end
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_o.valid = (state_q == S_EMIT);
  assign res_o.phys  = phys_q;
  assign res_o.oor   = oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cache_q <= '0;
    end else begin
      state_q <= state_d;
      cache_q <= cache_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    n_q    <= n_d;
    c_q    <= c_d;
    lo_q   <= lo_d;
    cnt_q  <= cnt_d;
    phys_q <= phys_d;
    oor_q  <= oor_d;
  end

  // Run-end table: one write port for loads, one registered read port.
  always_ff @(posedge clk_i) begin
    if (is_load && (32'(cmd_i.entry_index) < MAX_RUNS)) begin
      mem[IW'(cmd_i.entry_index)] <= RUN_END_BITS'(cmd_i.run_end_value);
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/run_end_physical_index_finder_core.sv
// Top level of the run-end index finder: stream ports, APB registers and
// the result register. Depends on reif_pkg and reif_seq.
//
// The block keeps a table of strictly increasing run ends, written by load
// items (tuser 0) one entry at a time, and answers query items (tuser 1):
// for the position start offset + logical_index it returns the least run
// number whose run end exceeds the position, or flags out_of_range when the
// position is at or beyond the last valid run end or num_runs is 0. A cached
// run number makes repeated queries into the same run cheap; any load or
// register write resets it to run 0. The block works on one item at a time
// and drops s_axis_tready_o while a query is in flight. A query reads one
// table entry per cycle through the single read port of the table memory,
// which sets the pace: it checks the last run end, then the cached run and,
// if needed, the run before it, then bisects what is left. The result moves
// into the output register as the sequencer returns to idle, and the output
// register lets the next item in while a result waits on m_axis_tready_i.
// Table entries are undefined after reset until loaded; there is no clearing
// pass, so the block is ready right after reset. Registers: the start offset
// at byte address 0, num_runs at address 4; num_runs above MAX_RUNS acts as
// MAX_RUNS. Write registers only while the block is idle.
module run_end_physical_index_finder_core import reif_pkg::*; #(
  parameter int MAX_RUNS     = 1024,
  parameter int RUN_END_BITS = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input items.
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // [9:0] entry_index, [40:10] run_end_value, [71:41] logical_index
  input  logic [71:0]       s_axis_tdata_i,
  // [0] action
  input  logic              s_axis_tuser_i,
  // Result items.
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // [9:0] physical_index, [15:10] zero
  output logic [15:0]       m_axis_tdata_o,
  // [0] out_of_range
  output logic              m_axis_tuser_o,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [OFF_W-1:0]  offset_q, offset_d;
  logic [NRUN_W-1:0] num_runs_q, num_runs_d;
  logic              cfg_wr;

  cmd_t cmd;
  res_t res;
  logic res_ready;

  logic              out_valid_q, out_valid_d;
  logic [PHYS_W-1:0] out_phys_q, out_phys_d;
  logic              out_oor_q, out_oor_d;

  // Register file. Writes complete in the access phase; pready is tied high.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    offset_d   = offset_q;
    num_runs_d = num_runs_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_OFFSET:   offset_d   = pwdata[OFF_W-1:0];
        REG_NUM_RUNS: num_runs_d = pwdata[NRUN_W-1:0];
        default:      offset_d   = offset_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_OFFSET:   prdata = 32'(offset_q);
      REG_NUM_RUNS: prdata = 32'(num_runs_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      num_runs_q <= '0;
    end else begin
      offset_q   <= offset_d;
      num_runs_q <= num_runs_d;
    end
  end

  // Unpack the accepted input item for the sequencer.
  assign cmd.valid         = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd.action        = s_axis_tuser_i;
  assign cmd.entry_index   = s_axis_tdata_i[9:0];
  assign cmd.run_end_value = s_axis_tdata_i[40:10];
  assign cmd.logical_index = s_axis_tdata_i[71:41];

  reif_seq #(
    .MAX_RUNS     (MAX_RUNS),
    .RUN_END_BITS (RUN_END_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_ready_o (s_axis_tready_o),
    .offset_i    (offset_q),
    .num_runs_i  (num_runs_q),
    .cfg_wr_i    (cfg_wr),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // Output register: takes a new result when empty or being drained.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_phys_d  = out_phys_q;
    out_oor_d   = out_oor_q;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
      out_phys_d  = res.phys;
      out_oor_d   = res.oor;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_phys_q <= out_phys_d;
    out_oor_q  <= out_oor_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = 16'(out_phys_q);
  assign m_axis_tuser_o  = out_oor_q;

endmodule

FILE: hdl/reif_chk.sv
// Port-level checker for the run-end index finder, bound to the top level.
// Depends on reif_pkg and run_end_physical_index_finder_core.
module reif_chk import reif_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // A query keeps the block busy for at least the cycle after its accept.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == ACT_QUERY) |=> !s_axis_tready_o)
    else $error("ready right after a query was accepted");

  // An out-of-range result always reports run 0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> (m_axis_tdata_o == 16'd0))
    else $error("out-of-range result with nonzero run number");

  // A load never produces a result item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == ACT_LOAD) && !m_axis_tvalid_o
      |=> !m_axis_tvalid_o)
    else $error("result appeared after a load");

endmodule

bind run_end_physical_index_finder_core reif_chk u_reif_chk (.*);
